FILE: src/bhie_pkg.sv
`default_nettype none
package bhie_pkg;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DUMP   = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic load_ins;
        logic rd_parent;
        logic wr_hole;
        logic wr_key;
        logic dump_start;
        logic dump_rd;
        logic emit_ok;
        logic emit_full;
        logic emit_empty;
    } t_cmd;

    typedef struct packed {
        logic count_full;
        logic count_zero;
        logic idx_zero;
        logic swap;
        logic rd_last;
    } t_stat;

endpackage
`default_nettype wire

FILE: src/bhie_ram.sv
`default_nettype none
module bhie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: src/bhie_ctrl.sv
`default_nettype none
module bhie_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_action,
    input  wire bhie_pkg::t_stat i_stat,
    output bhie_pkg::t_cmd     o_cmd,
    output logic               o_busy
);
    import bhie_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_RD    = 3'd1;
    localparam logic [2:0] S_INS_CMP   = 3'd2;
    localparam logic [2:0] S_INS_DONE  = 3'd3;
    localparam logic [2:0] S_DUMP      = 3'd4;
    localparam logic [2:0] S_DUMP_TAIL = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_action == ACT_INSERT) begin
                        if (i_stat.count_full) begin
                            o_cmd.emit_full = 1'b1;
                        end else begin
                            o_cmd.load_ins = 1'b1;
                            n_state        = S_INS_RD;
                        end
                    end else begin
                        if (i_stat.count_zero) begin
                            o_cmd.emit_empty = 1'b1;
                        end else begin
                            o_cmd.dump_start = 1'b1;
                            n_state          = S_DUMP;
                        end
                    end
                end
            end
            S_INS_RD: begin
                if (i_stat.idx_zero) begin
                    o_cmd.wr_key = 1'b1;
                    n_state      = S_INS_DONE;
                end else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state         = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_stat.swap) begin
                    o_cmd.wr_hole = 1'b1;
                    n_state       = S_INS_RD;
                end else begin
                    o_cmd.wr_key = 1'b1;
                    n_state      = S_INS_DONE;
                end
            end
            S_INS_DONE: begin
                o_cmd.emit_ok = 1'b1;
                n_state       = S_IDLE;
            end
            S_DUMP: begin
                o_cmd.dump_rd = 1'b1;
                if (i_stat.rd_last) begin
                    n_state = S_DUMP_TAIL;
                end
            end
            S_DUMP_TAIL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

FILE: src/bhie_dp.sv
`default_nettype none
module bhie_dp #(
    parameter int CAPACITY = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bhie_pkg::t_cmd     i_cmd,
    input  wire logic signed [31:0] i_key,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_data,
    output bhie_pkg::t_stat         o_stat,
    output logic                    o_strobe,
    output logic signed [31:0]      o_value,
    output logic [5:0]              o_position,
    output logic [6:0]              o_fill,
    output logic [1:0]              o_status,
    output logic                    o_last
);
    import bhie_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                 r_mode;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_idx;
    logic signed [31:0]   r_key;
    logic [AW-1:0]        r_rd_addr;
    logic                 r_pend;
    logic [AW-1:0]        r_pend_pos;
    logic                 r_strobe;
    logic signed [31:0]   r_value;
    logic [5:0]           r_pos;
    logic [6:0]           r_fill;
    logic [1:0]           r_status;
    logic                 r_last;

    logic [AW-1:0]        parent;
    logic [AW-1:0]        raddr;
    logic                 we;
    logic [31:0]          wdata;
    logic [31:0]          rdata;
    logic signed [31:0]   rkey;
    logic                 pend_last;

    assign parent = (r_idx - AW'(1)) >> 1;
    assign raddr  = i_cmd.rd_parent ? parent : r_rd_addr;
    assign we     = i_cmd.wr_hole | i_cmd.wr_key;
    assign wdata  = i_cmd.wr_hole ? rdata : r_key;
    assign rkey   = $signed(rdata);

    bhie_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_idx),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign pend_last         = (CW'(r_pend_pos) + CW'(1)) == r_count;
    assign o_stat.count_full = (r_count == CW'(CAPACITY));
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.idx_zero   = (r_idx == '0);
    assign o_stat.swap       = r_mode ? (rkey < r_key) : (rkey > r_key);
    assign o_stat.rd_last    = (CW'(r_rd_addr) + CW'(1)) == r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.wr_key) begin
                r_count <= r_count + CW'(1);
            end
            r_pend   <= i_cmd.dump_rd;
            r_strobe <= r_pend | i_cmd.emit_ok | i_cmd.emit_full | i_cmd.emit_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ins) begin
            r_key <= i_key;
            r_idx <= r_count[AW-1:0];
        end else if (i_cmd.wr_hole) begin
            r_idx <= parent;
        end
        if (i_cmd.dump_start) begin
            r_rd_addr <= '0;
        end else if (i_cmd.dump_rd) begin
            r_rd_addr  <= r_rd_addr + AW'(1);
        end
        if (i_cmd.dump_rd) begin
            r_pend_pos <= r_rd_addr;
        end
        if (r_pend) begin
            r_value  <= rkey;
            r_pos    <= 6'(r_pend_pos);
            r_fill   <= 7'(r_count);
            r_status <= ST_OK;
            r_last   <= pend_last;
        end else if (i_cmd.emit_ok | i_cmd.emit_full | i_cmd.emit_empty) begin
            r_value  <= '0;
            r_pos    <= '0;
            r_fill   <= 7'(r_count);
            r_last   <= 1'b1;
            if (i_cmd.emit_full) begin
                r_status <= ST_FULL;
            end else if (i_cmd.emit_empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end
    end

    assign o_strobe   = r_strobe;
    assign o_value    = r_value;
    assign o_position = r_pos;
    assign o_fill     = r_fill;
    assign o_status   = r_status;
    assign o_last     = r_last;

endmodule
`default_nettype wire

FILE: src/binary_heap_insert_engine.sv
`default_nettype none
// Binary heap priority queue held in one RAM of CAPACITY 32-bit signed keys.
// Pulse start while busy is low: action 0 inserts i_key and sifts it up
// (min-heap or max-heap per the configured order mode), action 1 dumps all
// stored keys in array order. Results appear on the o_ ports for exactly one
// cycle with o_strobe high and cannot be stalled, so the receiver must take
// them as they come. An insert keeps busy high while the key climbs k levels
// (k at most 6 at capacity 64): each level is a parent read and a
// compare-and-write on the single RAM read port. Its result strobes in the
// same cycle that busy falls. A dump keeps busy high while it reads the
// stored keys, which stream out one key per cycle, the last marked by
// o_last. An insert into a full heap, or a dump of an empty one, does not
// raise busy and returns its status in the next cycle. The order mode is
// written through the cfg channel, which is ready whenever the block is not
// busy.
module binary_heap_insert_engine #(
    parameter int CAPACITY = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_action,
    input  wire logic signed [31:0] i_key,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_data,
    output logic                    o_strobe,
    output logic signed [31:0]      o_value,
    output logic [5:0]              o_position,
    output logic [6:0]              o_fill,
    output logic [1:0]              o_status,
    output logic                    o_last
);
    import bhie_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = ~busy;

    bhie_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_action(i_action),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bhie_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_key     (i_key),
        .i_cfg_we  (i_cfg_valid & o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .o_stat    (stat),
        .o_strobe  (o_strobe),
        .o_value   (o_value),
        .o_position(o_position),
        .o_fill    (o_fill),
        .o_status  (o_status),
        .o_last    (o_last)
    );

    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == ST_FULL) |-> (o_fill == 7'(CAPACITY)) && o_last)
        else $error("full result without full fill");

    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == ST_EMPTY) |-> (o_fill == 7'd0) && o_last)
        else $error("empty result with nonzero fill");

    a_dump_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe && (o_position == $past(o_position) + 6'd1))
        else $error("dump stream broken");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_fill <= 7'(CAPACITY)))
        else $error("fill above capacity");

endmodule
`default_nettype wire
